[rtl/core/smsort_pkg.sv]
// Shared types, constants and key compare for the stable merge sorter.
// No dependencies; every other file of the block imports this package.
package smsort_pkg;

  localparam int MaxItems = 64;
  localparam int KeyBits  = 32;
  localparam int TagBits  = 16;
  localparam int IdxW     = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int CfgIdxW  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeySigned = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgOrderDesc = CfgIdxW'(1);

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [TagBits-1:0] tag_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  // one request to a store memory: one write port, two read ports
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr0;
    logic [IdxW-1:0] raddr1;
  } mem_req_t;

  // read issued toward the output stage
  typedef struct packed {
    logic vld;
    logic last;
    logic ovf;
  } emit_req_t;

  // true when key b must go strictly ahead of key a
  function automatic logic goes_before(key_t b, key_t a, logic is_signed, logic desc);
    key_t x;
    key_t y;
    x = a;
    y = b;
    if (is_signed) begin
      x[KeyBits-1] = ~x[KeyBits-1];
      y[KeyBits-1] = ~y[KeyBits-1];
    end
    return desc ? (y > x) : (y < x);
  endfunction

endpackage

[rtl/core/smsort_mem.sv]
// Entry store: one write port, two read ports with registered read data.
// Depends on smsort_pkg for the entry and request types.
module smsort_mem import smsort_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rd0_o,
  output entry_t   rd1_o
);

  entry_t mem_q [MaxItems];
  entry_t rd0_q;
  entry_t rd1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd0_q <= mem_q[req_i.raddr0];
      rd1_q <= mem_q[req_i.raddr1];
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

[rtl/core/smsort_seq.sv]
// Sequencer: loads items, runs the bottom-up merge passes between two stores,
// and issues the reads of the sorted run. Depends on smsort_pkg.
module smsort_seq import smsort_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  key_t               item_key_i,
  input  tag_t               item_tag_i,
  input  logic               item_last_i,
  input  entry_t             rd0_i,
  input  entry_t             rd1_i,
  output mem_req_t           req_a_o,
  output mem_req_t           req_b_o,
  output logic               src_o,
  input  logic               emit_ready_i,
  input  logic               emit_done_i,
  output emit_req_t          emit_o
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StMerge = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] width_q, width_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] mid_q, mid_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] k_q, k_d;
  logic            src_q, src_d;
  logic            ovf_q, ovf_d;
  logic            key_signed_q;
  logic            order_desc_q;

  logic [CntW:0]   sum_mid;
  logic [CntW:0]   sum_hi;
  logic [CntW:0]   dbl_width;
  logic [CntW-1:0] nmid;
  logic [CntW-1:0] nhi;
  logic            take_j;
  logic            issue;
  entry_t          win;
  mem_req_t        rreq;
  mem_req_t        wreq;
  logic            wr_a;
  logic            wr_b;

  assign sum_mid   = {1'b0, lo_q} + {1'b0, width_q};
  assign sum_hi    = sum_mid + {1'b0, width_q};
  assign dbl_width = {width_q, 1'b0};
  assign nmid      = (sum_mid < {1'b0, n_q}) ? sum_mid[CntW-1:0] : n_q;
  assign nhi       = (sum_hi < {1'b0, n_q}) ? sum_hi[CntW-1:0] : n_q;

  assign take_j = (i_q == mid_q) ||
                  ((j_q != hi_q) &&
                   goes_before(rd1_i.key, rd0_i.key, key_signed_q, order_desc_q));
  assign win    = take_j ? rd1_i : rd0_i;

  assign in_stall_o = (state_q != StLoad);
  assign src_o      = src_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    src_d   = src_q;
    ovf_d   = ovf_q;
    rreq    = '0;
    wreq    = '0;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    issue   = 1'b0;
    emit_o  = '0;

    unique case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (cnt_q != CntW'(MaxItems)) begin
            wreq.we        = 1'b1;
            wreq.waddr     = cnt_q[IdxW-1:0];
            wreq.wdata.key = item_key_i;
            wreq.wdata.tag = item_tag_i;
            wr_a           = 1'b1;
            cnt_d          = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_last_i) begin
            n_d     = cnt_d;
            width_d = CntW'(1);
            lo_d    = '0;
            src_d   = 1'b0;
            k_d     = '0;
            state_d = (cnt_d > CntW'(1)) ? StSetup : StEmit;
          end
        end
      end

      StSetup: begin
        mid_d       = nmid;
        hi_d        = nhi;
        i_d         = lo_q;
        j_d         = nmid;
        k_d         = lo_q;
        rreq.re     = 1'b1;
        rreq.raddr0 = lo_q[IdxW-1:0];
        rreq.raddr1 = nmid[IdxW-1:0];
        state_d     = StMerge;
      end

      StMerge: begin
        wreq.we    = 1'b1;
        wreq.waddr = k_q[IdxW-1:0];
        wreq.wdata = win;
        wr_a       = src_q;
        wr_b       = ~src_q;
        if (take_j) begin
          j_d = j_q + CntW'(1);
        end else begin
          i_d = i_q + CntW'(1);
        end
        k_d         = k_q + CntW'(1);
        // fetch the next heads so they are ready on the following cycle
        rreq.re     = 1'b1;
        rreq.raddr0 = i_d[IdxW-1:0];
        rreq.raddr1 = j_d[IdxW-1:0];
        if (k_d == hi_q) begin
          lo_d    = hi_q;
          state_d = StSetup;
          if (hi_q == n_q) begin
            src_d   = ~src_q;
            width_d = dbl_width[CntW-1:0];
            lo_d    = '0;
            if (dbl_width >= {1'b0, n_q}) begin
              k_d     = '0;
              state_d = StEmit;
            end
          end
        end
      end

      StEmit: begin
        issue       = (k_q != n_q) && emit_ready_i;
        rreq.re     = issue;
        rreq.raddr0 = k_q[IdxW-1:0];
        emit_o.vld  = issue;
        emit_o.last = ((k_q + CntW'(1)) == n_q);
        emit_o.ovf  = ovf_q;
        if (issue) begin
          k_d = k_q + CntW'(1);
        end
        if (emit_done_i) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = StLoad;
        end
      end

      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_comb begin
    req_a_o        = rreq;
    req_a_o.we     = wr_a;
    req_a_o.waddr  = wreq.waddr;
    req_a_o.wdata  = wreq.wdata;
    req_b_o        = rreq;
    req_b_o.we     = wr_b;
    req_b_o.waddr  = wreq.waddr;
    req_b_o.wdata  = wreq.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      n_q     <= '0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      src_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      src_q   <= src_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_signed_q <= 1'b1;
      order_desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeySigned: key_signed_q <= cfg_data_i;
        CfgOrderDesc: order_desc_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/smsort_out.sv]
// Output stage: holds read data in flight plus the result register, with stall.
// Depends on smsort_pkg for the entry and emit request types.
module smsort_out import smsort_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_req_t emit_i,
  input  entry_t    rdata_i,
  output logic      ready_o,
  output logic      done_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output key_t      out_key_o,
  output tag_t      out_tag_o,
  output logic      out_last_o,
  output logic      out_overflow_o
);

  logic   rv_q;
  logic   s1_last_q;
  logic   s1_ovf_q;
  logic   out_valid_q;
  entry_t out_q;
  logic   out_last_q;
  logic   out_ovf_q;
  logic   adv;
  logic   move;

  assign adv     = ~out_valid_q | ~out_stall_i;
  assign move    = rv_q & adv;
  assign ready_o = ~rv_q | adv;
  assign done_o  = out_valid_q & ~out_stall_i & out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rv_q <= emit_i.vld | (rv_q & ~adv);
      if (adv) begin
        out_valid_q <= rv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.vld) begin
      s1_last_q <= emit_i.last;
      s1_ovf_q  <= emit_i.last & emit_i.ovf;
    end
    if (move) begin
      out_q      <= rdata_i;
      out_last_q <= s1_last_q;
      out_ovf_q  <= s1_ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_key_o      = out_q.key;
  assign out_tag_o      = out_q.tag;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_ovf_q;

endmodule

[rtl/core/stable_merge_sorter_top.sv]
// Operation: items load into store A; after the last of n items, ceil(log2 n) merge
//   passes run with run widths doubling from 1, then the sorted run is read out through
//   the read register and the result register (straight after loading for a one-item
//   set), and one result follows per cycle while the output is not stalled.
// The input stays stalled from the last item of a set until its final result is taken;
//   sorting time is dominated by the merge passes through the single write port.
// Reset: asynchronous, active low; clears control, count and overflow, sets key_signed
//   to 1 and order_descending to 0. The stores are not cleared and need no clearing pass.
module stable_merge_sorter_top import smsort_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  // input transaction channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  key_t               item_key_i,
  input  tag_t               item_tag_i,
  input  logic               item_last_i,
  // result transaction channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output key_t               out_key_o,
  output tag_t               out_tag_o,
  output logic               out_last_o,
  output logic               out_overflow_o
);

  // Two ping-pong stores. Loading fills store A; each merge pass reads the
  // source store at the two run heads and writes the merged run to the other.
  mem_req_t  req_a;
  mem_req_t  req_b;
  entry_t    a_rd0;
  entry_t    a_rd1;
  entry_t    b_rd0;
  entry_t    b_rd1;
  entry_t    src_rd0;
  entry_t    src_rd1;
  logic      src;
  emit_req_t emit;
  logic      emit_ready;
  logic      emit_done;

  smsort_mem u_mem_a (
    .clk_i (clk_i),
    .req_i (req_a),
    .rd0_o (a_rd0),
    .rd1_o (a_rd1)
  );

  smsort_mem u_mem_b (
    .clk_i (clk_i),
    .req_i (req_b),
    .rd0_o (b_rd0),
    .rd1_o (b_rd1)
  );

  // Select the source store: its read data feeds the comparator while merging
  // and the output stage while the sorted run drains.
  assign src_rd0 = src ? b_rd0 : a_rd0;
  assign src_rd1 = src ? b_rd1 : a_rd1;

  // Sequencer: load, merge passes, and read issue for the sorted run.
  smsort_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_key_i   (item_key_i),
    .item_tag_i   (item_tag_i),
    .item_last_i  (item_last_i),
    .rd0_i        (src_rd0),
    .rd1_i        (src_rd1),
    .req_a_o      (req_a),
    .req_b_o      (req_b),
    .src_o        (src),
    .emit_ready_i (emit_ready),
    .emit_done_i  (emit_done),
    .emit_o       (emit)
  );

  // Output stage: the memory read register acts as a second buffer slot, so a
  // stall on the result side never drops a read already in flight.
  smsort_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .emit_i         (emit),
    .rdata_i        (src_rd0),
    .ready_o        (emit_ready),
    .done_o         (emit_done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_key_o      (out_key_o),
    .out_tag_o      (out_tag_o),
    .out_last_o     (out_last_o),
    .out_overflow_o (out_overflow_o)
  );

endmodule

[rtl/core/smsort_checker.sv]
// Port-level checks of the stable merge sorter, bound to the top level.
// Depends on smsort_pkg and stable_merge_sorter_top.
module smsort_checker import smsort_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic item_last_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input key_t out_key_o,
  input tag_t out_tag_o,
  input logic out_last_o,
  input logic out_overflow_o
);

  // no loading while results drain
  a_no_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // a last item closes the input until the run is out
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && item_last_i) |=> in_stall_o)
    else $error("input still open after last item");

  // overflow is reported only on the final result
  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_overflow_o) |-> out_last_o)
    else $error("overflow flag on a non-final result");

  // final result taken: ready for the next set
  a_reopen_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_last_o) |=> !in_stall_o)
    else $error("input not reopened after final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_key_o) && $stable(out_tag_o) && $stable(out_last_o)))
    else $error("stalled result changed");

endmodule

bind stable_merge_sorter_top smsort_checker u_smsort_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .item_last_i    (item_last_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_key_o      (out_key_o),
  .out_tag_o      (out_tag_o),
  .out_last_o     (out_last_o),
  .out_overflow_o (out_overflow_o)
);

[tb/smsort_order_check.sv]
// Checker for the stable merge sorter: watches the register port and both channels,
// predicts the sorted output of every loaded set and compares it field by field.
// Depends on smsort_pkg for widths, entry type and register indexes.
module smsort_order_check import smsort_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  key_t               item_key_i,
  input  tag_t               item_tag_i,
  input  logic               item_last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  key_t               out_key_i,
  input  tag_t               out_tag_i,
  input  logic               out_last_i,
  input  logic               out_overflow_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic ovf;
  } sorted_item_t;

  sorted_item_t sorted_q[$];
  entry_t       loaded_q[$];
  logic         dropped;
  logic         use_signed;
  logic         use_desc;
  int           mism;

  // true when key b belongs strictly ahead of key a
  function automatic logic ahead(key_t b, key_t a);
    if (use_signed) begin
      return use_desc ? ($signed(b) > $signed(a)) : ($signed(b) < $signed(a));
    end
    return use_desc ? (b > a) : (b < a);
  endfunction

  // stable insertion: a new entry only moves past entries it strictly beats
  function automatic void order_loaded_set();
    entry_t       ranked[$];
    sorted_item_t res;
    int           p;
    foreach (loaded_q[i]) begin
      p = ranked.size();
      while (p > 0 && ahead(loaded_q[i].key, ranked[p-1].key)) p--;
      ranked.insert(p, loaded_q[i]);
    end
    foreach (ranked[i]) begin
      res.key  = ranked[i].key;
      res.tag  = ranked[i].tag;
      res.last = (i == ranked.size() - 1);
      res.ovf  = res.last & dropped;
      sorted_q.push_back(res);
    end
    loaded_q.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t want;
    if (!rst_ni) begin
      sorted_q.delete();
      loaded_q.delete();
      dropped      = 1'b0;
      use_signed   = 1'b1;
      use_desc     = 1'b0;
      mism         = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgKeySigned) use_signed = cfg_data_i;
        else if (cfg_idx_i == CfgOrderDesc) use_desc = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (loaded_q.size() < MaxItems) loaded_q.push_back({item_key_i, item_tag_i});
        else dropped = 1'b1;
        if (item_last_i) order_loaded_set();
      end
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          mism++;
          if (mism <= 10) begin
            $display("%t unexpected result: key %h tag %h last %b ovf %b", $realtime,
                     out_key_i, out_tag_i, out_last_i, out_overflow_i);
          end
        end else begin
          want = sorted_q.pop_front();
          if (out_key_i !== want.key || out_tag_i !== want.tag ||
              out_last_i !== want.last || out_overflow_i !== want.ovf) begin
            mism++;
            if (mism <= 10) begin
              $display("%t mismatch: exp key %h tag %h last %b ovf %b", $realtime,
                       want.key, want.tag, want.last, want.ovf);
              $display("%t           got key %h tag %h last %b ovf %b", $realtime,
                       out_key_i, out_tag_i, out_last_i, out_overflow_i);
            end
          end
        end
      end
      mismatches_o <= mism;
      pending_o    <= sorted_q.size();
    end
  end

endmodule

[tb/stable_merge_sorter_top_tb.sv]
// Top of the stable merge sorter testbench: clock, reset, register writes, item
// stimulus and result back-pressure. Depends on smsort_pkg, the block and smsort_order_check.
module stable_merge_sorter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smsort_pkg::*;

  localparam int RandItems = 310;
  localparam int MaxGap    = 16;
  // long enough to cover loading and sorting a full set with no gaps, plus a long
  // stretch of stalled output while the next sets queue up at the input
  localparam int LongHold  = 1500;
  // index past the two registers; the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] CfgSpare = CfgIdxW'(3);

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic               cfg_data;
  logic               in_valid;
  logic               in_stall;
  key_t               item_key;
  tag_t               item_tag;
  logic               item_last;
  logic               out_valid;
  logic               out_stall;
  key_t               out_key;
  tag_t               out_tag;
  logic               out_last;
  logic               out_overflow;
  int                 mismatches;
  int                 pending;

  // steady and hold_req are shared between the sender and the receiver process
  bit                 steady;    // no random idle cycles on either side while set
  int                 hold_req;  // stall request for the receiver, in cycles
  int                 rand_sent;

  // corner keys mixed with duplicates, so equal keys test stability
  key_t dir_key [8] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                        32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
  tag_t dir_tag [8] = '{16'h0001, 16'h0002, 16'h0003, 16'h0004,
                        16'h0005, 16'h0006, 16'hFFFF, 16'h0000};

  stable_merge_sorter_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .item_key_i     (item_key),
    .item_tag_i     (item_tag),
    .item_last_i    (item_last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_key_o      (out_key),
    .out_tag_o      (out_tag),
    .out_last_o     (out_last),
    .out_overflow_o (out_overflow)
  );

  smsort_order_check order_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .item_key_i     (item_key),
    .item_tag_i     (item_tag),
    .item_last_i    (item_last),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_key_i      (out_key),
    .out_tag_i      (out_tag),
    .out_last_i     (out_last),
    .out_overflow_i (out_overflow),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one transaction after a random idle gap; return at the edge that takes it.
  // With no gap, valid simply stays high, so it is never dropped and raised in one step.
  task automatic send_item(key_t key, tag_t tag, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    item_key  <= key;
    item_tag  <= tag;
    item_last <= last;
    // hold the payload until the block stops stalling
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come out, then let the
  // block settle before anything touches the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // The task waits again after lowering the enable, so back-to-back writes never lower
  // and raise the enable in the same step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly corner and near-corner keys to force ties; the rest fully random.
  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(KeyBits-1){1'b1}}};
      3:       return {1'b1, {(KeyBits-1){1'b0}}};
      4:       return key_t'($urandom_range(0, 3));
      5:       return ~key_t'($urandom_range(0, 3));
      default: return key_t'($urandom);
    endcase
  endfunction

  // Send one set of random items; the last one carries the end-of-set mark.
  task automatic send_set(int size);
    for (int i = 0; i < size; i++) begin
      send_item(pick_key(), tag_t'($urandom), i == size - 1);
      rand_sent++;
    end
  endtask

  // Receiver: draw a stall length per accepted result and count it down cycle by
  // cycle; a hold request from the stimulus overrides the current count.
  initial begin
    int wait_left;
    out_stall = 1'b0;
    wait_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = steady ? 0 : $urandom_range(0, MaxGap);
      if (hold_req > 0) begin
        wait_left = hold_req;
        hold_req  = 0;
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int phase;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgKeySigned;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    item_key  = '0;
    item_tag  = '0;
    item_last = 1'b0;
    steady    = 1'b0;
    hold_req  = 0;
    rand_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (signed, ascending) first, untouched.
    // Single-item set.
    send_item(32'h8000_0000, 16'hFFFF, 1'b1);
    // Corner keys with duplicates in both halves of the set.
    for (int i = 0; i < 8; i++) send_item(dir_key[i], dir_tag[i], i == 7);
    // Two equal keys: arrival order must survive.
    send_item(32'h5A5A_5A5A, 16'h0001, 1'b0);
    send_item(32'h5A5A_5A5A, 16'h0002, 1'b1);
    wait_idle();
    // Same corner set, now unsigned and descending.
    write_reg(CfgKeySigned, 1'b0);
    write_reg(CfgOrderDesc, 1'b1);
    for (int i = 0; i < 8; i++) send_item(dir_key[i], dir_tag[i], i == 7);

    // Random phases: step through all four register settings, then random ones.
    // A few phases carry special sets: a full store under a long output hold, and
    // oversized sets that overflow and drop the end-of-set item itself.
    phase = 0;
    while (rand_sent < RandItems) begin
      // pause the sender until every expected result has come
      wait_idle();
      write_reg(CfgKeySigned, phase < 4 ? phase[0] : 1'($urandom_range(0, 1)));
      write_reg(CfgOrderDesc, phase < 4 ? phase[1] : 1'($urandom_range(0, 1)));
      if (phase == 2) write_reg(CfgSpare, 1'b1);
      steady = (phase == 1 || phase == 3);
      case (phase)
        1: begin
          // hold off the receiver; the following sets back up behind the output
          hold_req = LongHold;
          send_set(MaxItems);
        end
        2:       send_set(MaxItems + 3);
        5:       send_set(MaxItems + 2);
        default: ;
      endcase
      repeat (3) begin
        send_set(($urandom_range(0, 9) == 0) ? $urandom_range(13, MaxItems)
                                              : $urandom_range(1, 12));
      end
      phase++;
    end
    steady = 1'b0;

    // Drain everything, then let the block run on so that any stray result shows.
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #(4_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
